@@ src/efr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efr_pkg: shared types, codes and helpers for the escaped frame receiver
// Framing bytes, result codes, the descriptor passed from front to back,
// the CRC-16/XMODEM byte fold and the sensor word position table.
// ----------------------------------------------------------------------------
package efr_pkg;

    localparam int DEF_MAX_FRAME_BYTES = 32;

    localparam logic [7:0] SOF     = 8'h5A;
    localparam logic [7:0] ESC     = 8'h50;
    localparam logic [7:0] ESC_SOF = 8'h0A;
    localparam logic [7:0] ESC_ESC = 8'h05;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] LEN_SHORT  = 8'd13;
    localparam logic [7:0] LEN_PID    = 8'd15;
    localparam logic [7:0] LEN_SENSOR = 8'd29;

    localparam logic [7:0] ID_VERSION = 8'h05;
    localparam logic [7:0] ID_WHEEL   = 8'h03;

    localparam logic [7:0] SEQ_POS  = 8'd0;
    localparam logic [7:0] ADDR_POS = 8'd1;
    localparam logic [7:0] ID_POS   = 8'd3;
    localparam logic [7:0] OP_POS   = 8'd6;

    localparam int POS_W = 5;
    localparam logic [POS_W-1:0] WORD_BASE = 5'd7;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_CRC  = 2'd1;
    localparam logic [1:0] STATUS_KIND = 2'd2;
    localparam logic [1:0] STATUS_OVF  = 2'd3;

    localparam logic [1:0] KIND_VERSION = 2'd0;
    localparam logic [1:0] KIND_WHEEL   = 2'd1;
    localparam logic [1:0] KIND_PID     = 2'd2;
    localparam logic [1:0] KIND_SENSOR  = 2'd3;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] kind;
        logic [7:0] seq;
        logic [7:0] addr;
        logic [7:0] op;
        logic       bank;
    } t_desc;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [POS_W-1:0] sensor_pos(input logic [2:0] k);
        logic [POS_W-1:0] p;
        case (k)
            3'd0:    p = 5'd7;
            3'd1:    p = 5'd9;
            3'd2:    p = 5'd15;
            3'd3:    p = 5'd17;
            3'd4:    p = 5'd19;
            3'd5:    p = 5'd21;
            3'd6:    p = 5'd23;
            default: p = 5'd25;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

@@ src/efr_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efr_in_if: received byte channel
// Valid/ready channel carrying one raw serial byte per transaction.
// ----------------------------------------------------------------------------
interface efr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

@@ src/efr_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efr_out_if: frame result channel
// Valid/ready channel carrying one decoded word or status per transaction.
// ----------------------------------------------------------------------------
interface efr_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [1:0]         frame_kind;
    logic [7:0]         sequence_res;
    logic [7:0]         address;
    logic [7:0]         operation;
    logic [2:0]         word_index;
    logic signed [15:0] word_value;
    logic               last;

    modport source (output valid, output status, output frame_kind, output sequence_res,
                    output address, output operation, output word_index,
                    output word_value, output last, input ready);
    modport sink   (input valid, input status, input frame_kind, input sequence_res,
                    input address, input operation, input word_index,
                    input word_value, input last, output ready);
endinterface
`default_nettype wire

@@ src/efr_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efr_ram: generic RAM, one write port, two registered read ports
// Read data updates only on a read enable and holds otherwise.
// ----------------------------------------------------------------------------
module efr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule
`default_nettype wire

@@ src/efr_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efr_queue: two-entry frame descriptor queue
// Decouples the deframing front end from the result back end.
// ----------------------------------------------------------------------------
module efr_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire efr_pkg::t_desc i_data,
    output logic               o_full,
    output logic               o_valid,
    output efr_pkg::t_desc     o_data,
    input  wire logic          i_pop
);

    efr_pkg::t_desc r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_cnt    = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

@@ src/efr_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efr_front: deframer, unescaper, CRC check and frame classifier
// Writes unescaped bytes into one of two frame buffers, runs the CRC and
// pushes one descriptor per closed frame.
// ----------------------------------------------------------------------------
module efr_front #(
    parameter int MAX_FRAME_BYTES = efr_pkg::DEF_MAX_FRAME_BYTES
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    efr_in_if.sink                    i_rx,
    input  wire logic                 i_q_full,
    input  wire efr_pkg::t_release    i_release,
    output logic                      o_push,
    output efr_pkg::t_desc            o_desc,
    output logic                      o_ram_we,
    output logic [$clog2(MAX_FRAME_BYTES):0] o_ram_waddr,
    output logic [7:0]                o_ram_wdata
);

    localparam int AW = $clog2(MAX_FRAME_BYTES);
    localparam logic [15:0] CRC_OPEN = efr_pkg::crc_fold(16'h0000, efr_pkg::SOF);

    typedef struct packed {
        logic [7:0]  count;
        logic [15:0] crc;
        logic        ovf;
        logic [7:0]  h1;
        logic [7:0]  h2;
        logic [7:0]  seq;
        logic [7:0]  addr;
        logic [7:0]  id;
        logic [7:0]  op;
    } t_acc;

    function automatic t_acc store_byte(input t_acc a, input logic [7:0] s);
        t_acc r;
        r = a;
        if (a.count >= 8'd2) begin
            r.crc = efr_pkg::crc_fold(a.crc, a.h2);
        end
        if (32'(a.count) >= MAX_FRAME_BYTES) begin
            r.ovf = 1'b1;
        end
        if (a.count == efr_pkg::SEQ_POS) begin
            r.seq = s;
        end
        if (a.count == efr_pkg::ADDR_POS) begin
            r.addr = s;
        end
        if (a.count == efr_pkg::ID_POS) begin
            r.id = s;
        end
        if (a.count == efr_pkg::OP_POS) begin
            r.op = s;
        end
        r.h2 = a.h1;
        r.h1 = s;
        if (a.count != 8'hFF) begin
            r.count = a.count + 8'd1;
        end
        return r;
    endfunction

    t_acc       r_acc;
    t_acc       n_acc;
    t_acc       acc1;
    t_acc       acc2;
    logic       r_in_frame;
    logic       n_in_frame;
    logic       r_pend;
    logic       n_pend;
    logic       r_bank;
    logic       n_bank;
    logic [1:0] r_busy;
    logic [1:0] n_busy;

    logic       accept;
    logic [7:0] b;
    logic       open;
    logic       close;
    logic       new_pend;
    logic       v0;
    logic       v1;
    logic [7:0] s0;
    logic [7:0] s1;
    logic [8:0] wr_idx;
    logic       wr_any;

    assign i_rx.ready = !i_q_full && (r_in_frame || !r_busy[~r_bank]);
    assign accept     = i_rx.valid && i_rx.ready;
    assign b          = i_rx.rx_byte;

    always_comb begin
        open     = 1'b0;
        close    = 1'b0;
        new_pend = 1'b0;
        v0       = 1'b0;
        v1       = 1'b0;
        s0       = efr_pkg::ESC;
        s1       = b;
        n_pend   = r_pend;
        if (accept) begin
            if (!r_in_frame) begin
                open = (b == efr_pkg::SOF);
            end else if (b == efr_pkg::SOF) begin
                close  = 1'b1;
                v0     = r_pend;
                n_pend = 1'b0;
            end else begin
                if (r_pend) begin
                    n_pend = 1'b0;
                    v0     = 1'b1;
                    if (b == efr_pkg::ESC_SOF) begin
                        s0 = efr_pkg::SOF;
                    end else if (b == efr_pkg::ESC_ESC) begin
                        s0 = efr_pkg::ESC;
                    end else if (b == efr_pkg::ESC) begin
                        new_pend = 1'b1;
                    end else begin
                        v1 = 1'b1;
                    end
                end else if (b == efr_pkg::ESC) begin
                    new_pend = 1'b1;
                end else begin
                    v0 = 1'b1;
                    s0 = b;
                end
                if (new_pend) begin
                    n_pend = 1'b1;
                end
            end
        end

        acc1 = v0 ? store_byte(r_acc, s0) : r_acc;
        acc2 = v1 ? store_byte(acc1, s1) : acc1;

        n_acc = acc2;
        if (open) begin
            n_acc.count = 8'd0;
            n_acc.crc   = CRC_OPEN;
            n_acc.ovf   = 1'b0;
        end

        n_in_frame = r_in_frame;
        if (open) begin
            n_in_frame = 1'b1;
        end else if (close) begin
            n_in_frame = 1'b0;
        end

        n_busy = r_busy;
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
        n_bank = r_bank;
        if (open) begin
            n_busy[~r_bank] = 1'b1;
            n_bank          = ~r_bank;
        end
    end

    // Escape is written ahead at its slot; a following 0x0A or 0x05 replaces it.
    always_comb begin
        wr_idx      = {1'b0, r_acc.count};
        o_ram_wdata = s0;
        wr_any      = 1'b0;
        if (new_pend) begin
            wr_idx      = {1'b0, acc2.count};
            o_ram_wdata = efr_pkg::ESC;
            wr_any      = 1'b1;
        end else if (v1) begin
            wr_idx      = {1'b0, r_acc.count} + 9'd1;
            o_ram_wdata = s1;
            wr_any      = 1'b1;
        end else if (v0) begin
            wr_any      = 1'b1;
        end
        o_ram_we    = wr_any && (32'(wr_idx) < MAX_FRAME_BYTES);
        o_ram_waddr = {r_bank, wr_idx[AW-1:0]};
    end

    always_comb begin
        o_push      = close;
        o_desc      = '0;
        o_desc.bank = r_bank;
        if (acc2.ovf) begin
            o_desc.status = efr_pkg::STATUS_OVF;
        end else if (acc2.count < 8'd2) begin
            o_desc.status = efr_pkg::STATUS_KIND;
        end else if (acc2.h2 != acc2.crc[15:8] || acc2.h1 != acc2.crc[7:0]) begin
            o_desc.status = efr_pkg::STATUS_CRC;
        end else begin
            o_desc.status = efr_pkg::STATUS_OK;
            if (acc2.count == efr_pkg::LEN_SHORT && acc2.id == efr_pkg::ID_VERSION) begin
                o_desc.kind = efr_pkg::KIND_VERSION;
            end else if (acc2.count == efr_pkg::LEN_SHORT && acc2.id == efr_pkg::ID_WHEEL) begin
                o_desc.kind = efr_pkg::KIND_WHEEL;
            end else if (acc2.count == efr_pkg::LEN_PID) begin
                o_desc.kind = efr_pkg::KIND_PID;
            end else if (acc2.count == efr_pkg::LEN_SENSOR) begin
                o_desc.kind = efr_pkg::KIND_SENSOR;
            end else begin
                o_desc.status = efr_pkg::STATUS_KIND;
            end
            if (o_desc.status == efr_pkg::STATUS_OK) begin
                o_desc.seq  = acc2.seq;
                o_desc.addr = acc2.addr;
                o_desc.op   = acc2.op;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pend     <= 1'b0;
            r_bank     <= 1'b0;
            r_busy     <= 2'b00;
            r_acc      <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_pend     <= n_pend;
            r_bank     <= n_bank;
            r_busy     <= n_busy;
            r_acc      <= n_acc;
        end
    end

endmodule
`default_nettype wire

@@ src/efr_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efr_back: result sequencer
// Pops frame descriptors, reads payload words from the frame buffer and
// emits one result per word, or one status result for a rejected frame.
// ----------------------------------------------------------------------------
module efr_back #(
    parameter int MAX_FRAME_BYTES = efr_pkg::DEF_MAX_FRAME_BYTES
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_head_valid,
    input  wire efr_pkg::t_desc       i_head,
    output logic                      o_pop,
    output efr_pkg::t_release         o_release,
    output logic                      o_ram_re,
    output logic [$clog2(MAX_FRAME_BYTES):0] o_ram_raddr_a,
    output logic [$clog2(MAX_FRAME_BYTES):0] o_ram_raddr_b,
    input  wire logic [7:0]           i_ram_rdata_a,
    input  wire logic [7:0]           i_ram_rdata_b,
    efr_out_if.source                 o_res
);

    localparam int AW = $clog2(MAX_FRAME_BYTES);

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] kind;
        logic [7:0] seq;
        logic [7:0] addr;
        logic [7:0] op;
        logic [2:0] idx;
        logic       last;
        logic       ok;
    } t_word;

    logic [2:0]  r_idx;
    logic [2:0]  n_idx;
    logic        r_s1_v;
    logic        n_s1_v;
    t_word       r_s1;
    t_word       n_s1;
    logic        r_out_v;
    logic        n_out_v;
    t_word       r_out;
    logic [15:0] r_out_word;

    logic                    ok;
    logic [2:0]              last_idx;
    logic                    s1_move;
    logic                    issue;
    logic                    is_last;
    logic [efr_pkg::POS_W-1:0] pos;

    assign s1_move = r_s1_v && (!r_out_v || o_res.ready);
    assign issue   = i_head_valid && (!r_s1_v || s1_move);
    assign ok      = (i_head.status == efr_pkg::STATUS_OK);

    always_comb begin
        case (i_head.kind)
            efr_pkg::KIND_PID:    last_idx = 3'd2;
            efr_pkg::KIND_SENSOR: last_idx = 3'd7;
            default:              last_idx = 3'd1;
        endcase
        is_last = !ok || (r_idx == last_idx);

        if (i_head.kind == efr_pkg::KIND_SENSOR) begin
            pos = efr_pkg::sensor_pos(r_idx);
        end else begin
            pos = efr_pkg::WORD_BASE + {1'b0, r_idx, 1'b0};
        end
        o_ram_re      = issue && ok;
        o_ram_raddr_a = {i_head.bank, AW'(pos)};
        o_ram_raddr_b = {i_head.bank, AW'(pos + 5'd1)};

        o_pop             = issue && is_last;
        o_release.valid   = o_pop;
        o_release.bank    = i_head.bank;

        n_idx = r_idx;
        if (issue) begin
            n_idx = is_last ? 3'd0 : r_idx + 3'd1;
        end

        n_s1        = r_s1;
        n_s1.status = i_head.status;
        n_s1.kind   = i_head.kind;
        n_s1.seq    = i_head.seq;
        n_s1.addr   = i_head.addr;
        n_s1.op     = i_head.op;
        n_s1.idx    = ok ? r_idx : 3'd0;
        n_s1.last   = is_last;
        n_s1.ok     = ok;

        n_s1_v = issue ? 1'b1 : (s1_move ? 1'b0 : r_s1_v);
        n_out_v = s1_move ? 1'b1 : (o_res.ready ? 1'b0 : r_out_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_s1_v  <= n_s1_v;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1 <= n_s1;
        end
        if (s1_move) begin
            r_out      <= r_s1;
            r_out_word <= r_s1.ok ? {i_ram_rdata_a, i_ram_rdata_b} : 16'h0000;
        end
    end

    assign o_res.valid        = r_out_v;
    assign o_res.status       = r_out.status;
    assign o_res.frame_kind   = r_out.kind;
    assign o_res.sequence_res = r_out.seq;
    assign o_res.address      = r_out.addr;
    assign o_res.operation    = r_out.op;
    assign o_res.word_index   = r_out.idx;
    assign o_res.word_value   = $signed(r_out_word);
    assign o_res.last         = r_out.last;

endmodule
`default_nettype wire

@@ src/escaped_frame_receiver_crc16_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// escaped_frame_receiver_crc16_core: byte-stuffed frame receiver, CRC-16
// i_rx takes one raw serial byte per transaction; o_res gives one result
// per payload word of a good frame, or one status result for a bad frame.
// Bytes are accepted one per cycle while i_rx.ready is high. A closing 0x5A
// pushes its frame's descriptor; the words pass the issue and output stages
// one per cycle while o_res is ready, each read from a two-port frame buffer.
// Two frame buffers alternate between frames: a frame is assembled in one
// while the results of the previous one are read out of the other, and a
// two-entry descriptor queue sits between the deframer and the result side.
// When o_res stalls, results and descriptors hold. Between frames i_rx.ready
// stays low while the other buffer still holds a frame whose last word has
// not been issued, and rises once that buffer is released.
// Reset (synchronous, active low) returns the deframer to waiting for a
// start byte, empties the queue and the result stages and frees both
// buffers; buffer contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_crc16_core #(
    parameter int MAX_FRAME_BYTES = efr_pkg::DEF_MAX_FRAME_BYTES
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    efr_in_if.sink    i_rx,
    efr_out_if.source o_res
);

    localparam int AW = $clog2(MAX_FRAME_BYTES);

    efr_pkg::t_desc    push_desc;
    efr_pkg::t_desc    head_desc;
    efr_pkg::t_release release_bank;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_valid;
    logic              ram_we;
    logic [AW:0]       ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [AW:0]       ram_raddr_a;
    logic [AW:0]       ram_raddr_b;
    logic [7:0]        ram_rdata_a;
    logic [7:0]        ram_rdata_b;

    efr_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (i_rx),
        .i_q_full    (q_full),
        .i_release   (release_bank),
        .o_push      (push),
        .o_desc      (push_desc),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata)
    );

    efr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_desc),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (head_desc),
        .i_pop   (pop)
    );

    efr_ram #(
        .WIDTH (8),
        .DEPTH (2 << AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_re      (ram_re),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    efr_back #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (q_valid),
        .i_head        (head_desc),
        .o_pop         (pop),
        .o_release     (release_bank),
        .o_ram_re      (ram_re),
        .o_ram_raddr_a (ram_raddr_a),
        .o_ram_raddr_b (ram_raddr_b),
        .i_ram_rdata_a (ram_rdata_a),
        .i_ram_rdata_b (ram_rdata_b),
        .o_res         (o_res)
    );

endmodule
`default_nettype wire
